// ===== sv/esc_pkg.sv =====
// Shared types, constants and fixed-point helpers for the sensor compensation core.
// No dependencies; imported by esc_sdiv64, esc_humidity and the top-level core.
package esc_pkg;

   localparam logic [19:0] TEMP_SKIP      = 20'h80000;
   localparam logic [15:0] HUM_SKIP       = 16'h8000;
   localparam logic [31:0] TFINE_OFFSET_P = 32'd128000;
   localparam logic [20:0] PRESS_BASE     = 21'd1048576;
   localparam logic [63:0] PRESS_SCALE    = 64'd3125;
   localparam logic [63:0] PRESS_BIAS     = 64'h0000_8000_0000_0000;
   localparam logic [31:0] TFINE_OFFSET_H = 32'd76800;
   localparam logic [31:0] HUM_ROUND_A    = 32'd16384;
   localparam logic [31:0] HUM_BIAS_B     = 32'd2097152;
   localparam logic [31:0] HUM_ROUND_B    = 32'd8192;
   localparam logic [31:0] HUM_BIAS_T3    = 32'd32768;
   localparam logic [31:0] HUM_MAX_RAW    = 32'd419430400;
   localparam logic [16:0] HUM_MAX        = 17'd102400;
   localparam logic [31:0] TEMP_ROUND     = 32'd128;

   localparam int DIV_W = 64;

   typedef enum logic [2:0] {
      CSR_TEMP       = 3'd0,
      CSR_PRESS_LOW  = 3'd1,
      CSR_PRESS_HIGH = 3'd2,
      CSR_PRESS_NINE = 3'd3,
      CSR_HUM        = 3'd4,
      CSR_HUM_SIX    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [7:0]  h1;
      logic [15:0] h2;
      logic [7:0]  h3;
      logic [15:0] h4;
      logic [15:0] h5;
      logic [7:0]  h6;
   } hum_coeff_type;

   function automatic logic [31:0] sx16to32(input logic [15:0] x);
      return {{16{x[15]}}, x};
   endfunction

   function automatic logic [31:0] sx8to32(input logic [7:0] x);
      return {{24{x[7]}}, x};
   endfunction

   function automatic logic [63:0] sx16to64(input logic [15:0] x);
      return {{48{x[15]}}, x};
   endfunction

   function automatic logic [63:0] sx32to64(input logic [31:0] x);
      return {{32{x[31]}}, x};
   endfunction

   function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned sh);
      logic signed [31:0] sx;
      sx = x;
      return sx >>> sh;
   endfunction

   function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned sh);
      logic signed [63:0] sx;
      sx = x;
      return sx >>> sh;
   endfunction

endpackage

// ===== sv/esc_delay.sv =====
// Enabled shift-register delay line used to balance pipeline branches.
// No dependencies.
module esc_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] sr_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         sr_ff[0] <= din;
      end
   end

   for (genvar i = 1; i < DEPTH; i++) begin : g_tap
      always_ff @(posedge clock) begin
         if (en) begin
            sr_ff[i] <= sr_ff[i-1];
         end
      end
   end

   assign dout = sr_ff[DEPTH-1];

endmodule

// ===== sv/esc_mul64.sv =====
// Two-stage 64x64 multiplier keeping the low 64 bits, built from 32x32 partial products.
// No dependencies.
module esc_mul64 (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic [63:0] p
);

   logic [63:0] ll_ff, ll_in;
   logic [31:0] lh_ff, lh_in;
   logic [31:0] hl_ff, hl_in;
   logic [63:0] p_ff, p_in;

   // high x high only lands above bit 63
   always_comb begin
      ll_in = {32'b0, a[31:0]} * {32'b0, b[31:0]};
      lh_in = a[31:0] * b[63:32];
      hl_in = a[63:32] * b[31:0];
      p_in  = ll_ff + {lh_ff + hl_ff, 32'b0};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff <= ll_in;
         lh_ff <= lh_in;
         hl_ff <= hl_in;
         p_ff  <= p_in;
      end
   end

   assign p = p_ff;

endmodule

// ===== sv/esc_sdiv64.sv =====
// Pipelined 64-bit signed divider, truncating toward zero, one quotient bit per stage.
// Depends on esc_pkg.
module esc_sdiv64
   import esc_pkg::*;
(
   input  logic             clock,
   input  logic             en,
   input  logic [DIV_W-1:0] num,
   input  logic [DIV_W-1:0] den,
   output logic [DIV_W-1:0] quo
);

   logic [DIV_W-1:0] rem_ff [DIV_W];
   logic [DIV_W-1:0] dq_ff  [DIV_W+1];
   logic [DIV_W-1:0] ad_ff  [DIV_W];
   logic             neg_ff [DIV_W+1];
   logic [DIV_W-1:0] q_ff, q_in;
   logic [DIV_W-1:0] an_in, ad_in;

   always_comb begin
      an_in = num[DIV_W-1] ? (~num + 1'b1) : num;
      ad_in = den[DIV_W-1] ? (~den + 1'b1) : den;
      q_in  = neg_ff[DIV_W] ? (~dq_ff[DIV_W] + 1'b1) : dq_ff[DIV_W];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= '0;
         dq_ff[0]  <= an_in;
         ad_ff[0]  <= ad_in;
         neg_ff[0] <= num[DIV_W-1] ^ den[DIV_W-1];
         q_ff      <= q_in;
      end
   end

   // restoring step: dividend bits shift out of dq as quotient bits shift in
   for (genvar k = 1; k <= DIV_W; k++) begin : g_step
      logic [DIV_W:0] trial, diff;
      assign trial = {rem_ff[k-1], dq_ff[k-1][DIV_W-1]};
      assign diff  = trial - {1'b0, ad_ff[k-1]};

      always_ff @(posedge clock) begin
         if (en) begin
            dq_ff[k]  <= {dq_ff[k-1][DIV_W-2:0], ~diff[DIV_W]};
            neg_ff[k] <= neg_ff[k-1];
         end
      end

      if (k < DIV_W) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= diff[DIV_W] ? trial[DIV_W-1:0] : diff[DIV_W-1:0];
               ad_ff[k]  <= ad_ff[k-1];
            end
         end
      end
   end

   assign quo = q_ff;

endmodule

// ===== sv/esc_humidity.sv =====
// Eleven-stage 32-bit humidity compensation pipeline, fed with fine temperature.
// Depends on esc_pkg. Output is the clamped unsigned Q7.10 value before skip masking.
module esc_humidity
   import esc_pkg::*;
(
   input  logic          clock,
   input  logic          en,
   input  hum_coeff_type coeff,
   input  logic [31:0]   tfine,
   input  logic [15:0]   adc_h,
   output logic [16:0]   humidity
);

   logic [31:0] h2s, h5s, h6s;
   logic [31:0] v1_ff, v1_in, ah1_ff, ah1_in;
   logic [31:0] hv2_ff, hv2_in, vh6_ff, vh6_in, vh3_ff, vh3_in, ah2_ff;
   logic [31:0] a3_ff, a3_in, t6_ff, t6_in, t3_ff, t3_in;
   logic [31:0] m4_ff, m4_in, a4_ff;
   logic [31:0] e5_ff, e5_in, a5_ff;
   logic [31:0] f6_ff, f6_in, a6_ff;
   logic [31:0] b7_ff, b7_in, a7_ff;
   logic [31:0] v8_ff, v8_in;
   logic [31:0] w9, ww9_ff, ww9_in, v9_ff;
   logic [31:0] g10_ff, g10_in, v10_ff;
   logic [31:0] vv;
   logic [16:0] hum_ff, hum_in;

   always_comb begin
      h2s    = sx16to32(coeff.h2);
      h5s    = sx16to32(coeff.h5);
      h6s    = sx8to32(coeff.h6);
      v1_in  = tfine - TFINE_OFFSET_H;
      ah1_in = {2'b0, adc_h, 14'b0} - {coeff.h4[11:0], 20'b0};
      hv2_in = h5s * v1_ff;
      vh6_in = v1_ff * h6s;
      vh3_in = v1_ff * {24'b0, coeff.h3};
      a3_in  = asr32(ah2_ff - hv2_ff + HUM_ROUND_A, 15);
      t6_in  = asr32(vh6_ff, 10);
      t3_in  = asr32(vh3_ff, 11) + HUM_BIAS_T3;
      m4_in  = t6_ff * t3_ff;
      e5_in  = asr32(m4_ff, 10) + HUM_BIAS_B;
      f6_in  = e5_ff * h2s;
      b7_in  = asr32(f6_ff + HUM_ROUND_B, 14);
      v8_in  = a7_ff * b7_ff;
      w9     = asr32(v8_ff, 15);
      ww9_in = w9 * w9;
      g10_in = asr32(ww9_ff, 7) * {24'b0, coeff.h1};
      vv     = v10_ff - asr32(g10_ff, 4);
      // clamp to 0..100 %RH
      if (vv[31]) begin
         hum_in = '0;
      end else if (vv > HUM_MAX_RAW) begin
         hum_in = HUM_MAX;
      end else begin
         hum_in = vv[28:12];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v1_ff  <= v1_in;
         ah1_ff <= ah1_in;
         hv2_ff <= hv2_in;
         vh6_ff <= vh6_in;
         vh3_ff <= vh3_in;
         ah2_ff <= ah1_ff;
         a3_ff  <= a3_in;
         t6_ff  <= t6_in;
         t3_ff  <= t3_in;
         m4_ff  <= m4_in;
         a4_ff  <= a3_ff;
         e5_ff  <= e5_in;
         a5_ff  <= a4_ff;
         f6_ff  <= f6_in;
         a6_ff  <= a5_ff;
         b7_ff  <= b7_in;
         a7_ff  <= a6_ff;
         v8_ff  <= v8_in;
         ww9_ff <= ww9_in;
         v9_ff  <= v8_ff;
         g10_ff <= g10_in;
         v10_ff <= v9_ff;
         hum_ff <= hum_in;
      end
   end

   assign humidity = hum_ff;

endmodule

// ===== sv/env_sensor_compensation_core.sv =====
// Environmental sensor compensation core: one raw temperature/pressure/humidity
// transaction per cycle in while req_stall is low, one compensated result per transaction out.
// Depends on esc_pkg, esc_delay, esc_mul64, esc_sdiv64 and esc_humidity.
//
// The core is a single 85-stage pipeline that accepts a transaction every cycle while req_stall is low.
// Its depth is set by the pressure path: 64-bit products run through two-stage
// multipliers built from 32x32 partial products, and the pressure division is a
// 66-stage divider producing one quotient bit per stage. When the result is held
// (rsp_stall with rsp_valid) the whole pipeline freezes and req_stall is raised;
// nothing is dropped or repeated. Calibration registers are written through the
// csr_ port, which is always ready; write them only while the pipeline is empty.
module env_sensor_compensation_core
   import esc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [19:0] req_raw_temperature,
   input  logic [19:0] req_raw_pressure,
   input  logic [15:0] req_raw_humidity,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_temperature_centi,
   output logic [31:0] rsp_pressure_q24_8,
   output logic [16:0] rsp_humidity_q22_10,
   output logic        rsp_temperature_skipped,
   output logic        rsp_humidity_skipped,
   output logic        rsp_pressure_divisor_zero,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int PIPE_LAT = 85;

   // calibration registers
   logic [47:0] temp_cf_ff;
   logic [63:0] press_lo_ff, press_hi_ff, hum_cf_ff;
   logic [15:0] press_p9_ff;
   logic [7:0]  hum_h6_ff;
   hum_coeff_type hum_cf;

   logic adv;
   logic [PIPE_LAT-1:0] vld_ff;

   logic [31:0] t2, t3;
   logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

   logic [31:0] s1_d1_ff, s1_d1_in, s1_b_ff, s1_b_in;
   logic [20:0] s1_pr_ff, s1_pr_in;
   logic [15:0] s1_adch_ff;
   logic [1:0]  s1_skip_ff, s1_skip_in;
   logic [31:0] s2_a_ff, s2_a_in, s2_bb_ff, s2_bb_in;
   logic [31:0] s3_a_ff, s3_bs_ff, s3_bs_in;
   logic [31:0] s4_tfine_ff, s4_tfine_in;
   logic [63:0] s5_x1_ff, s5_x1_in;
   logic [31:0] s5_temp_ff, s5_temp_in;
   logic [63:0] m_xx, m_x5, m_x2, m_x5_d, m_x2_d, x2a, x1a;
   logic [63:0] s10_x2_ff, s10_x2_in, s10_x1_ff, s10_x1_in;
   logic [20:0] pr_d;
   logic [63:0] s11_xo_ff, s11_xo_in, s11_nd_ff, s11_nd_in;
   logic [63:0] x1c, num, x1d;
   logic        pzero, pzero_d;
   logic [63:0] quo, qs, qs_d, t9, u9, p8q, p8q_d, quo_d;
   logic [63:0] s84_sum_ff, s84_sum_in, pfin;
   logic [15:0] adch_d;
   logic [16:0] hum_raw, hum_d;
   logic [31:0] temp_d;
   logic [1:0]  skip_d;

   logic [31:0] rsp_temp_ff, rsp_temp_in, rsp_press_ff, rsp_press_in;
   logic [16:0] rsp_hum_ff, rsp_hum_in;
   logic        rsp_tskip_ff, rsp_tskip_in, rsp_hskip_ff, rsp_hskip_in;
   logic        rsp_pzero_ff, rsp_pzero_in;

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_cf_ff  <= '0;
         press_lo_ff <= '0;
         press_hi_ff <= '0;
         press_p9_ff <= '0;
         hum_cf_ff   <= '0;
         hum_h6_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_TEMP:       temp_cf_ff  <= csr_data[47:0];
            CSR_PRESS_LOW:  press_lo_ff <= csr_data;
            CSR_PRESS_HIGH: press_hi_ff <= csr_data;
            CSR_PRESS_NINE: press_p9_ff <= csr_data[15:0];
            CSR_HUM:        hum_cf_ff   <= csr_data;
            CSR_HUM_SIX:    hum_h6_ff   <= csr_data[7:0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      t2 = sx16to32(temp_cf_ff[31:16]);
      t3 = sx16to32(temp_cf_ff[47:32]);
      p1 = {48'b0, press_lo_ff[15:0]};
      p2 = sx16to64(press_lo_ff[31:16]);
      p3 = sx16to64(press_lo_ff[47:32]);
      p4 = sx16to64(press_lo_ff[63:48]);
      p5 = sx16to64(press_hi_ff[15:0]);
      p6 = sx16to64(press_hi_ff[31:16]);
      p7 = sx16to64(press_hi_ff[47:32]);
      p8 = sx16to64(press_hi_ff[63:48]);
      p9 = sx16to64(press_p9_ff);
      hum_cf.h1 = hum_cf_ff[7:0];
      hum_cf.h2 = hum_cf_ff[23:8];
      hum_cf.h3 = hum_cf_ff[31:24];
      hum_cf.h4 = hum_cf_ff[47:32];
      hum_cf.h5 = hum_cf_ff[63:48];
      hum_cf.h6 = hum_h6_ff;
   end

   // ------------------------------------------------------- flow control
   assign adv       = !(vld_ff[PIPE_LAT-1] && rsp_stall);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PIPE_LAT-2:0], req_valid};
      end
   end

   // ---------------------------------------------------------- temperature
   always_comb begin
      s1_d1_in    = {15'b0, req_raw_temperature[19:3]} - {15'b0, temp_cf_ff[15:0], 1'b0};
      s1_b_in     = {16'b0, req_raw_temperature[19:4]} - {16'b0, temp_cf_ff[15:0]};
      s1_pr_in    = PRESS_BASE - {1'b0, req_raw_pressure};
      s1_skip_in  = {req_raw_humidity == HUM_SKIP, req_raw_temperature == TEMP_SKIP};
      s2_a_in     = asr32(s1_d1_ff * t2, 11);
      s2_bb_in    = s1_b_ff * s1_b_ff;
      s3_bs_in    = asr32(s2_bb_ff, 12) * t3;
      s4_tfine_in = s3_a_ff + asr32(s3_bs_ff, 14);
      s5_x1_in    = sx32to64(s4_tfine_ff) - {32'b0, TFINE_OFFSET_P};
      s5_temp_in  = asr32({s4_tfine_ff[29:0], 2'b0} + s4_tfine_ff + TEMP_ROUND, 8);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_d1_ff    <= s1_d1_in;
         s1_b_ff     <= s1_b_in;
         s1_pr_ff    <= s1_pr_in;
         s1_adch_ff  <= req_raw_humidity;
         s1_skip_ff  <= s1_skip_in;
         s2_a_ff     <= s2_a_in;
         s2_bb_ff    <= s2_bb_in;
         s3_a_ff     <= s2_a_ff;
         s3_bs_ff    <= s3_bs_in;
         s4_tfine_ff <= s4_tfine_in;
         s5_x1_ff    <= s5_x1_in;
         s5_temp_ff  <= s5_temp_in;
      end
   end

   // ------------------------------------------------------------- pressure
   esc_mul64 u_mul_xx (.clock, .en(adv), .a(s5_x1_ff), .b(s5_x1_ff), .p(m_xx));
   esc_mul64 u_mul_x5 (.clock, .en(adv), .a(s5_x1_ff), .b(p5), .p(m_x5));
   esc_mul64 u_mul_x2 (.clock, .en(adv), .a(s5_x1_ff), .b(p2), .p(m_x2));
   esc_mul64 u_mul_p6 (.clock, .en(adv), .a(m_xx), .b(p6), .p(x2a));
   esc_mul64 u_mul_p3 (.clock, .en(adv), .a(m_xx), .b(p3), .p(x1a));

   esc_delay #(.WIDTH(128), .DEPTH(2)) u_dly_x52 (
      .clock, .en(adv), .din({m_x5, m_x2}), .dout({m_x5_d, m_x2_d})
   );
   esc_delay #(.WIDTH(21), .DEPTH(9)) u_dly_pr (
      .clock, .en(adv), .din(s1_pr_ff), .dout(pr_d)
   );

   always_comb begin
      s10_x2_in = x2a + {m_x5_d[46:0], 17'b0} + {p4[28:0], 35'b0};
      s10_x1_in = asr64(x1a, 8) + {m_x2_d[51:0], 12'b0};
      s11_xo_in = PRESS_BIAS + s10_x1_ff;
      s11_nd_in = {12'b0, pr_d, 31'b0} - s10_x2_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s10_x2_ff <= s10_x2_in;
         s10_x1_ff <= s10_x1_in;
         s11_xo_ff <= s11_xo_in;
         s11_nd_ff <= s11_nd_in;
      end
   end

   esc_mul64 u_mul_p1 (.clock, .en(adv), .a(s11_xo_ff), .b(p1), .p(x1c));
   esc_mul64 u_mul_sc (.clock, .en(adv), .a(s11_nd_ff), .b(PRESS_SCALE), .p(num));

   assign x1d   = asr64(x1c, 33);
   assign pzero = (x1d == '0);

   esc_sdiv64 u_div (.clock, .en(adv), .num(num), .den(x1d), .quo(quo));

   assign qs = asr64(quo, 13);

   esc_mul64 u_mul_p9 (.clock, .en(adv), .a(p9), .b(qs), .p(t9));
   esc_mul64 u_mul_qq (.clock, .en(adv), .a(t9), .b(qs_d), .p(u9));
   esc_mul64 u_mul_p8 (.clock, .en(adv), .a(p8), .b(quo), .p(p8q));

   esc_delay #(.WIDTH(64), .DEPTH(2)) u_dly_qs (
      .clock, .en(adv), .din(qs), .dout(qs_d)
   );
   esc_delay #(.WIDTH(64), .DEPTH(2)) u_dly_p8q (
      .clock, .en(adv), .din(p8q), .dout(p8q_d)
   );
   esc_delay #(.WIDTH(64), .DEPTH(4)) u_dly_quo (
      .clock, .en(adv), .din(quo), .dout(quo_d)
   );

   assign s84_sum_in = quo_d + asr64(u9, 25) + asr64(p8q_d, 19);

   always_ff @(posedge clock) begin
      if (adv) begin
         s84_sum_ff <= s84_sum_in;
      end
   end

   assign pfin = asr64(s84_sum_ff, 8) + {p7[59:0], 4'b0};

   // ------------------------------------------------------------- humidity
   esc_delay #(.WIDTH(16), .DEPTH(3)) u_dly_adch (
      .clock, .en(adv), .din(s1_adch_ff), .dout(adch_d)
   );

   esc_humidity u_hum (
      .clock, .en(adv), .coeff(hum_cf), .tfine(s4_tfine_ff), .adc_h(adch_d),
      .humidity(hum_raw)
   );

   // --------------------------------------------------- branch alignment
   esc_delay #(.WIDTH(17), .DEPTH(69)) u_dly_hum (
      .clock, .en(adv), .din(hum_raw), .dout(hum_d)
   );
   esc_delay #(.WIDTH(32), .DEPTH(79)) u_dly_temp (
      .clock, .en(adv), .din(s5_temp_ff), .dout(temp_d)
   );
   esc_delay #(.WIDTH(2), .DEPTH(83)) u_dly_skip (
      .clock, .en(adv), .din(s1_skip_ff), .dout(skip_d)
   );
   esc_delay #(.WIDTH(1), .DEPTH(71)) u_dly_pzero (
      .clock, .en(adv), .din(pzero), .dout(pzero_d)
   );

   // -------------------------------------------------------- result stage
   // skip_d[0]: temperature skipped, skip_d[1]: humidity skipped
   always_comb begin
      rsp_temp_in  = skip_d[0] ? '0 : temp_d;
      rsp_press_in = (skip_d[0] || pzero_d) ? '0 : pfin[31:0];
      rsp_hum_in   = (skip_d[0] || skip_d[1]) ? '0 : hum_d;
      rsp_tskip_in = skip_d[0];
      rsp_hskip_in = skip_d[1] && !skip_d[0];
      rsp_pzero_in = pzero_d && !skip_d[0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_temp_ff  <= rsp_temp_in;
         rsp_press_ff <= rsp_press_in;
         rsp_hum_ff   <= rsp_hum_in;
         rsp_tskip_ff <= rsp_tskip_in;
         rsp_hskip_ff <= rsp_hskip_in;
         rsp_pzero_ff <= rsp_pzero_in;
      end
   end

   assign rsp_valid                 = vld_ff[PIPE_LAT-1];
   assign rsp_temperature_centi     = rsp_temp_ff;
   assign rsp_pressure_q24_8        = rsp_press_ff;
   assign rsp_humidity_q22_10       = rsp_hum_ff;
   assign rsp_temperature_skipped   = rsp_tskip_ff;
   assign rsp_humidity_skipped      = rsp_hskip_ff;
   assign rsp_pressure_divisor_zero = rsp_pzero_ff;

   // ----------------------------------------------------------- assertions
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline valid bits moved while output held");

   a_tskip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_temperature_skipped |->
         rsp_temperature_centi == '0 && rsp_pressure_q24_8 == '0 &&
         rsp_humidity_q22_10 == '0 && !rsp_humidity_skipped && !rsp_pressure_divisor_zero)
      else $error("skipped temperature transaction carries nonzero result");

   a_pzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pressure_divisor_zero |-> rsp_pressure_q24_8 == '0)
      else $error("zero divisor flagged but pressure nonzero");

   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_humidity_q22_10 <= HUM_MAX)
      else $error("humidity above clamp");

endmodule
